// File: sv/splhr_pkg.sv
package splhr_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 24;

  // Widths of the hold and decay registers and of the hold counter.
  localparam int CNT_BITS  = 16;
  localparam int HOLD_BITS = 17;

  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_VOLUME    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_SAMPLES  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_SAMPLES = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
  } unit_ctl_t;

endpackage

// File: sv/splhr_smul.sv
module splhr_smul #(
  parameter int A_W = splhr_pkg::GAIN_FRAC_BITS_DEF + 1,
  parameter int B_W = splhr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  splhr_pkg::unit_ctl_t  ctl,
  input  logic [A_W-1:0]        a,
  input  logic [B_W-1:0]        b,
  output logic [A_W+B_W-1:0]    prod
);
  import splhr_pkg::*;

  // Shift-add multiplier: one multiplier bit per cycle while step is high, LSB first. The
  // multiplier sits in the low part of the accumulator and shifts out.
  logic [A_W-1:0]     a_r;
  logic [A_W+B_W-1:0] acc_r;
  logic [A_W+B_W-1:0] acc_nxt;
  logic [A_W:0]       sum;

  always_comb begin
    sum = {1'b0, acc_r[A_W+B_W-1:B_W]} + (acc_r[0] ? {1'b0, a_r} : '0);
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = {{A_W{1'b0}}, b};
    end else if (ctl.step) begin
      acc_nxt = {sum, acc_r[B_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= a;
    end
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;

endmodule

// File: sv/splhr_sdiv.sv
module splhr_sdiv #(
  parameter int N_W = splhr_pkg::GAIN_FRAC_BITS_DEF + 1,
  parameter int D_W = splhr_pkg::CNT_BITS
) (
  input  logic                  clk,
  input  splhr_pkg::unit_ctl_t  ctl,
  input  logic [D_W-1:0]        rem_init,
  input  logic [N_W-1:0]        num,
  input  logic [D_W-1:0]        den,
  output logic [N_W-1:0]        quo,
  output logic [D_W-1:0]        rem
);
  import splhr_pkg::*;

  // Restoring divider, one quotient bit per cycle while step is high. The starting remainder
  // must be below the divisor.
  logic [N_W-1:0] num_r;
  logic [N_W-1:0] quo_r;
  logic [D_W-1:0] rem_r;
  logic [D_W-1:0] den_r;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  always_comb begin
    trial = {rem_r, num_r[N_W-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      num_r <= num;
      quo_r <= '0;
      rem_r <= rem_init;
      den_r <= den;
    end else if (ctl.step) begin
      num_r <= {num_r[N_W-2:0], 1'b0};
      quo_r <= {quo_r[N_W-2:0], ge};
      rem_r <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

// File: sv/stereo_peak_limiter_hold_release.sv
// Stereo peak limiter with hold and linear release. Each input beat is one
// signed sample pair; each pair yields exactly one output beat with both
// samples scaled by the gain after this pair's update, rounded to nearest,
// plus that gain in unsigned 1.GAIN_FRAC_BITS form. One pair is processed
// at a time. Every pair takes two passes of the bit-serial multipliers:
// one for the clipping tests, one for output scaling. A pair that sets a
// new peak also runs the shared bit-serial divider between the passes,
// which first forms the new gain and then the release step. A finished
// beat waits in the output register while the next pair is taken in.
// Write configuration only while idle.
module stereo_peak_limiter_hold_release #(
  parameter int SAMPLE_BITS    = splhr_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = splhr_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [SAMPLE_BITS-1:0]            in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]            in_right_in,
  input  logic                                     in_end_of_block,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [SAMPLE_BITS-1:0]            out_left_out,
  output logic signed [SAMPLE_BITS-1:0]            out_right_out,
  output logic                                     out_block_end_out,
  output logic [GAIN_FRAC_BITS:0]                  out_gain_now,
  input  logic                                     cfg_we,
  input  logic [splhr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [((SAMPLE_BITS-1 > splhr_pkg::CNT_BITS) ?
                 SAMPLE_BITS-1 : splhr_pkg::CNT_BITS)-1:0] cfg_wdata
);
  import splhr_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int GF   = GAIN_FRAC_BITS;
  localparam int GW   = GF + 1;
  localparam int AW   = GW + 1;
  localparam int PXW  = AW + SB;
  localparam int PYW  = GW + SB;
  localparam int LW   = SB - 1 + GF;
  localparam int DW   = (SB > CNT_BITS) ? SB : CNT_BITS;
  localparam int NMAX = (GW > SB) ? GW : SB;
  localparam int CTW  = $clog2(NMAX + 1);

  localparam logic [GW-1:0] UNITY = {1'b1, {GF{1'b0}}};
  localparam logic [GF-1:0] HALF  = {1'b1, {(GF-1){1'b0}}};

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PREP   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_DIV1   = 4'd4;
  localparam logic [3:0] ST_GAP    = 4'd5;
  localparam logic [3:0] ST_DIV2   = 4'd6;
  localparam logic [3:0] ST_STEP   = 4'd7;
  localparam logic [3:0] ST_SCLD   = 4'd8;
  localparam logic [3:0] ST_SCALE  = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [CTW-1:0]       cnt_r, cnt_nxt;

  logic [SB-2:0]        mv_r;
  logic [CNT_BITS-1:0]  hs_r;
  logic [CNT_BITS-1:0]  dec_r;

  logic [GW-1:0]        gain_r, gain_nxt;
  logic [GW-1:0]        step_r, step_nxt;
  logic [HOLD_BITS-1:0] hold_r, hold_nxt;

  logic [SB-1:0]        ml_r, mr_r, peak_r;
  logic                 nl_r, nr_r, eob_r;
  logic [SB-1:0]        ml_in, mr_in;

  logic                 out_valid_r, out_valid_nxt;
  logic [SB-1:0]        out_l_r, out_r_r;
  logic                 out_eob_r;
  logic [GW-1:0]        out_gain_r;

  unit_ctl_t            mul_ctl, dv_ctl;
  logic [AW-1:0]        mx_a;
  logic [SB-1:0]        mx_b, my_b;
  logic [PXW-1:0]       prod_x;
  logic [PYW-1:0]       prod_y;

  logic [DW-1:0]        dv_rem_init, dv_den;
  logic [GW-1:0]        dv_num, dv_quo;
  logic [DW-1:0]        dv_rem;

  logic [AW-1:0]        gsum;
  logic [GW-1:0]        gcap;
  logic [HOLD_BITS-1:0] hold_inc;
  logic [LW-1:0]        limit;
  logic                 upd, cond_a, cond_b, go_div, fin_load;
  logic [CNT_BITS-1:0]  dec_eff;
  logic [GW-1:0]        gap;
  logic [PXW-1:0]       rnd_x;
  logic [PYW-1:0]       rnd_y;
  logic [SB-1:0]        rx, ry, sl, sr;

  always_comb begin
    ml_in    = in_left_in[SB-1] ? (~unsigned'(in_left_in) + 1'b1) : unsigned'(in_left_in);
    mr_in    = in_right_in[SB-1] ? (~unsigned'(in_right_in) + 1'b1)
                                 : unsigned'(in_right_in);
    gsum     = {1'b0, gain_r} + {1'b0, step_r};
    gcap     = (gsum > {1'b0, UNITY}) ? UNITY : gsum[GW-1:0];
    hold_inc = (&hold_r) ? hold_r : hold_r + 1'b1;
    limit    = {mv_r, {GF{1'b0}}};
    upd      = (gain_r != UNITY) || (peak_r > {1'b0, mv_r});
    cond_a   = (gain_r != UNITY) && (prod_x <= PXW'(limit));
    cond_b   = prod_y > PYW'(limit);
    go_div   = upd && !cond_a && cond_b;
    dec_eff  = (dec_r == '0) ? CNT_BITS'(1) : dec_r;
    gap      = UNITY - dv_quo;

    rnd_x    = prod_x + PXW'(HALF);
    rnd_y    = prod_y + PYW'(HALF);
    rx       = rnd_x[GF +: SB];
    ry       = rnd_y[GF +: SB];
    sl       = nl_r ? (~rx + 1'b1) : rx;
    sr       = nr_r ? (~ry + 1'b1) : ry;
  end

  always_comb begin
    mul_ctl.load = (state_r == ST_PREP) || (state_r == ST_SCLD);
    mul_ctl.step = (state_r == ST_MUL) || (state_r == ST_SCALE);
    dv_ctl.load  = ((state_r == ST_DECIDE) && go_div) || (state_r == ST_GAP);
    dv_ctl.step  = (state_r == ST_DIV1) || (state_r == ST_DIV2);

    mx_a = (state_r == ST_PREP) ? gsum : AW'(gain_r);
    mx_b = (state_r == ST_PREP) ? peak_r : ml_r;
    my_b = (state_r == ST_PREP) ? peak_r : mr_r;

    dv_rem_init = (state_r == ST_DECIDE) ? DW'(mv_r) : '0;
    dv_num      = (state_r == ST_GAP) ? gap : '0;
    dv_den      = (state_r == ST_DECIDE) ? DW'(peak_r) : DW'(dec_eff);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    gain_nxt  = gain_r;
    step_nxt  = step_r;
    hold_nxt  = hold_r;
    fin_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_nxt   = CTW'(SB);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CTW'(1)) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_SCLD;
        if (upd) begin
          if (cond_a) begin
            hold_nxt = hold_inc;
            if (hold_inc > {1'b0, hs_r}) begin
              gain_nxt = gcap;
            end
          end else if (cond_b) begin
            hold_nxt  = '0;
            cnt_nxt   = CTW'(GF);
            state_nxt = ST_DIV1;
          end else begin
            hold_nxt = '0;
          end
        end
      end
      ST_DIV1: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CTW'(1)) begin
          state_nxt = ST_GAP;
        end
      end
      ST_GAP: begin
        gain_nxt  = dv_quo;
        cnt_nxt   = CTW'(GW);
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CTW'(1)) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        step_nxt  = dv_quo + GW'(dv_rem != '0);
        state_nxt = ST_SCLD;
      end
      ST_SCLD: begin
        cnt_nxt   = CTW'(SB);
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CTW'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          fin_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || fin_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      gain_r      <= UNITY;
      step_r      <= '0;
      hold_r      <= '0;
      mv_r        <= '1;
      hs_r        <= '0;
      dec_r       <= CNT_BITS'(1);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      gain_r      <= gain_nxt;
      step_r      <= step_nxt;
      hold_r      <= hold_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_VOLUME:    mv_r  <= cfg_wdata[SB-2:0];
          REG_HOLD_SAMPLES:  hs_r  <= cfg_wdata[CNT_BITS-1:0];
          REG_DECAY_SAMPLES: dec_r <= cfg_wdata[CNT_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ml_r   <= ml_in;
      mr_r   <= mr_in;
      peak_r <= (mr_in > ml_in) ? mr_in : ml_in;
      nl_r   <= in_left_in[SB-1];
      nr_r   <= in_right_in[SB-1];
      eob_r  <= in_end_of_block;
    end
    if (fin_load) begin
      out_l_r    <= sl;
      out_r_r    <= sr;
      out_eob_r  <= eob_r;
      out_gain_r <= gain_r;
    end
  end

  splhr_smul #(.A_W(AW), .B_W(SB)) u_mul_x (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    (mx_a),
    .b    (mx_b),
    .prod (prod_x)
  );

  splhr_smul #(.A_W(GW), .B_W(SB)) u_mul_y (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    (gain_r),
    .b    (my_b),
    .prod (prod_y)
  );

  splhr_sdiv #(.N_W(GW), .D_W(DW)) u_div (
    .clk      (clk),
    .ctl      (dv_ctl),
    .rem_init (dv_rem_init),
    .num      (dv_num),
    .den      (dv_den),
    .quo      (dv_quo),
    .rem      (dv_rem)
  );

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_left_out      = signed'(out_l_r);
  assign out_right_out     = signed'(out_r_r);
  assign out_block_end_out = out_eob_r;
  assign out_gain_now      = out_gain_r;

`ifndef SYNTHESIS
  a_gain_le_unity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain_now <= UNITY)
    else $error("output gain above unity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second pair accepted while busy");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) && go_div |-> {1'b0, mv_r} < peak_r)
    else $error("gain division started with peak not above limit");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |=> (step_r != '0) || (gain_r == UNITY))
    else $error("zero release step below unity gain");
`endif

endmodule

// File: verif/stereo_peak_limiter_hold_release_test.sv
module stereo_peak_limiter_hold_release_test;
  import splhr_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int GF = GAIN_FRAC_BITS_DEF;
  localparam int CFG_W = (SB - 1 > CNT_BITS) ? SB - 1 : CNT_BITS;
  localparam int MAX_MAG = 2 ** (SB - 1) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * GF + 2 * SB + 20;

  typedef logic signed [SB-1:0] sample_t;
  typedef longint unsigned wide_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic block_end;
    logic [GF:0] gain;
  } limited_pair_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SB - 1){1'b0}}};
  localparam logic [GF:0] UNITY_GAIN = {1'b1, {GF{1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_left_in = '0;
  sample_t in_right_in = '0;
  logic in_end_of_block = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_left_out;
  sample_t out_right_out;
  logic out_block_end_out;
  logic [GF:0] out_gain_now;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [SB-2:0] max_volume = '1;
  logic [CNT_BITS-1:0] hold_samples = '0;
  logic [CNT_BITS-1:0] decay_samples = 1;
  logic [GF:0] gain_level = UNITY_GAIN;
  logic [GF:0] release_step = '0;
  logic [HOLD_BITS-1:0] hold_count = '0;

  limited_pair_t pending_pairs[$];
  int mismatches = 0;
  int pairs_checked = 0;
  int settings_applied = 0;
  int gain_cuts = 0;
  int gain_raises = 0;
  int idle_cycles = 0;
  int out_stall_left = 0;
  bit no_idle = 1'b0;

  stereo_peak_limiter_hold_release DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_left_in(in_left_in),
    .in_right_in(in_right_in),
    .in_end_of_block(in_end_of_block),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_left_out(out_left_out),
    .out_right_out(out_right_out),
    .out_block_end_out(out_block_end_out),
    .out_gain_now(out_gain_now),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic sample_t scale_sample(sample_t s, wide_t g);
    int v;
    wide_t m;
    wide_t q;
    v = s;
    m = (v < 0) ? -v : v;
    q = (m * g + (wide_t'(1) << (GF - 1))) >> GF;
    return (v < 0) ? sample_t'(-q) : sample_t'(q);
  endfunction

  function automatic limited_pair_t apply_limiter(sample_t left, sample_t right, logic eob);
    int sl;
    int sr;
    wide_t peak;
    wide_t g;
    wide_t st;
    wide_t lim;
    wide_t d;
    wide_t gap;
    limited_pair_t res;
    sl = left;
    sr = right;
    if (sl < 0) sl = -sl;
    if (sr < 0) sr = -sr;
    peak = (sr > sl) ? sr : sl;
    g = gain_level;
    st = release_step;
    lim = wide_t'(max_volume) << GF;
    if (g != UNITY_GAIN || peak > max_volume) begin
      if (g != UNITY_GAIN && (g + st) * peak <= lim) begin
        if (hold_count != '1) hold_count = hold_count + 1'b1;
        if (hold_count > hold_samples) begin
          g = g + st;
          if (g > UNITY_GAIN) g = UNITY_GAIN;
          gain_raises++;
        end
      end else if (peak * g > lim) begin
        d = (decay_samples == 0) ? 1 : decay_samples;
        hold_count = '0;
        g = lim / peak;
        if (g > UNITY_GAIN) g = UNITY_GAIN;
        gap = UNITY_GAIN - g;
        release_step = (GF + 1)'((gap + d - 1) / d);
        gain_cuts++;
      end else begin
        hold_count = '0;
      end
      gain_level = (GF + 1)'(g);
    end
    res.left = scale_sample(left, gain_level);
    res.right = scale_sample(right, gain_level);
    res.block_end = eob;
    res.gain = gain_level;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 30)
      $display("Mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic send_pair(sample_t left, sample_t right, logic eob);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_in <= left;
    in_right_in <= right;
    in_end_of_block <= eob;
    do @(posedge clk); while (!in_ready);
    pending_pairs.push_back(apply_limiter(left, right, eob));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pairs.size() > 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_VOLUME: max_volume = value[SB-2:0];
      REG_HOLD_SAMPLES: hold_samples = value[CNT_BITS-1:0];
      REG_DECAY_SAMPLES: decay_samples = value[CNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [CFG_W-1:0] vol, logic [CFG_W-1:0] hold,
                                logic [CFG_W-1:0] decay);
    wait_drained();
    write_register(REG_MAX_VOLUME, vol);
    write_register(REG_HOLD_SAMPLES, hold);
    write_register(REG_DECAY_SAMPLES, decay);
    settings_applied++;
  endtask

  function automatic sample_t pick_sample(int vol);
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      mag = $urandom_range(vol / 2, vol + vol / 4 + 1);
      if (mag > MAX_MAG) mag = MAX_MAG;
    end else if (r < 75) begin
      mag = $urandom_range(0, vol / 3);
    end else if (r < 90) begin
      return sample_t'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: return SAMPLE_MIN;
        1: return SAMPLE_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom_range(0, 1) ? sample_t'(-mag) : sample_t'(mag);
  endfunction

  task automatic test_unity_passthrough();
    send_pair(100, -100, 1'b1);
    send_pair(SAMPLE_MAX, -MAX_MAG, 1'b0);
    send_pair(0, 0, 1'b1);
  endtask

  task automatic test_full_scale();
    send_pair(SAMPLE_MIN, 5, 1'b0);
    send_pair(7, SAMPLE_MIN, 1'b1);
    send_pair(1, -1, 1'b0);
  endtask

  task automatic test_rounding_ties();
    apply_settings(1000, 0, 1);
    send_pair(2000, -3, 1'b1);
    send_pair(3, -2000, 1'b0);
    send_pair(0, 0, 1'b1);
  endtask

  task automatic test_hold_and_release();
    apply_settings(1000, 3, 5);
    send_pair(4000, 0, 1'b0);
    repeat (2) send_pair(50, -50, 1'b0);
    send_pair(0, -4000, 1'b1);
    repeat (10) send_pair(sample_t'($urandom_range(0, 400) - 200),
                          sample_t'($urandom_range(0, 400) - 200),
                          1'($urandom_range(0, 1)));
  endtask

  task automatic test_zero_volume_and_decay();
    apply_settings(0, 0, 0);
    send_pair(1, 0, 1'b0);
    send_pair(0, 0, 1'b1);
  endtask

  task automatic test_random_program(int phases, int per_phase);
    int vol;
    int hold;
    int decay;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0: apply_settings('1, 0, 1);
        1: apply_settings(0, 0, 0);
        2: apply_settings(CFG_W'(MAX_MAG), '1, '1);
        3: apply_settings(1, 1, '1);
        default: begin
          vol = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(200, 24000);
          hold = ($urandom_range(0, 99) < 15) ? $urandom : $urandom_range(0, 12);
          decay = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
          apply_settings(CFG_W'(vol), CFG_W'(hold), CFG_W'(decay));
        end
      endcase
      no_idle = (p % 4 == 2);
      vol = max_volume;
      for (int i = 0; i < per_phase; i++)
        send_pair(pick_sample(vol), pick_sample(vol), 1'($urandom_range(0, 1)));
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : drive_out_ready
    int gap;
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_ready <= 1'b0;
    end else begin
      gap = pick_gap();
      out_ready <= (gap == 0);
      out_stall_left = (gap > 0) ? gap - 1 : 0;
    end
  end

  always @(posedge clk) begin : check_beat
    limited_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("output beat with no pair pending", 0, 1);
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (out_left_out !== want.left)
          report_mismatch("left_out", want.left, out_left_out);
        if (out_right_out !== want.right)
          report_mismatch("right_out", want.right, out_right_out);
        if (out_block_end_out !== want.block_end)
          report_mismatch("block_end_out", want.block_end, out_block_end_out);
        if (out_gain_now !== want.gain)
          report_mismatch("gain_now", want.gain, out_gain_now);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_unity_passthrough();
    test_full_scale();
    test_rounding_ties();
    test_hold_and_release();
    test_zero_volume_and_decay();
    test_random_program(13, 146);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d sample pairs under %0d limiter settings, extremes included.",
             pairs_checked, settings_applied);
    $display("The gain was cut %0d times and raised by a release step %0d times.",
             gain_cuts, gain_raises);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/splhr_pkg.sv
sv/splhr_smul.sv
sv/splhr_sdiv.sv
sv/stereo_peak_limiter_hold_release.sv
verif/stereo_peak_limiter_hold_release_test.sv
